// ----- design/sspa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspa_pkg: shared types and constants for the sky separation pipeline
// Angle formats, Q1.30 helpers and the CORDIC arctangent step table.
// ----------------------------------------------------------------------------
package sspa_pkg;

    localparam int ANGLE_BITS = 32;          // 2^32 per full turn
    localparam int FRAC_BITS  = 30;          // Q1.30 fraction bits
    localparam int CW         = 34;          // CORDIC datapath width
    localparam int RAD_W      = 61;          // radicand width, 1 - u*u in Q2.60
    localparam int ROOT_W     = 31;          // root width, up to 2^30

    typedef logic signed [31:0]         q30_t;
    typedef logic [ANGLE_BITS-1:0]      angle_t;
    typedef logic signed [CW-1:0]       cw_t;
    typedef logic [ROOT_W-1:0]          root_t;

    localparam q30_t ONE_Q30      = 32'sh4000_0000;
    localparam cw_t  GAIN_Q30     = 34'sd652032874;
    localparam cw_t  QUARTER_TURN = 34'sh0_4000_0000;
    localparam cw_t  HALF_TURN    = 34'sh0_8000_0000;
    localparam logic [RAD_W-1:0] RAD_ONE = 61'h1000_0000_0000_0000;

    // atan(2^-i) in 2^-32 turn, rounded
    function automatic cw_t step_angle(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return cw_t'({2'b00, v});
    endfunction

    // clamp a CORDIC value to [-1, 1] in Q1.30
    function automatic q30_t sat_q30(input cw_t v);
        if (v > cw_t'(ONE_Q30)) begin
            return ONE_Q30;
        end else if (v < -cw_t'(ONE_Q30)) begin
            return -ONE_Q30;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/sspa_rot.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspa_rot: pipelined rotation CORDIC, sine and cosine in lanes
// One rotation step per stage, quadrant mapping and clamp in the last stage.
// ----------------------------------------------------------------------------
module sspa_rot
    import sspa_pkg::*;
#(
    parameter int STAGES = 30,
    parameter int LANES  = 3,
    parameter int SIDE_W = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  angle_t            ang [LANES],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output q30_t              sin_q [LANES],
    output q30_t              cos_q [LANES],
    output logic [SIDE_W-1:0] out_side
);

    cw_t         x_reg  [STAGES+1][LANES];
    cw_t         y_reg  [STAGES+1][LANES];
    cw_t         z_reg  [STAGES+1][LANES];
    logic [1:0]  q_reg  [STAGES+1][LANES];
    cw_t         x_next [STAGES+1][LANES];
    cw_t         y_next [STAGES+1][LANES];
    cw_t         z_next [STAGES+1][LANES];
    logic [1:0]  q_next [STAGES+1][LANES];
    logic [SIDE_W-1:0] side_reg [STAGES+1];
    logic [STAGES:0]   v_reg;

    q30_t sin_reg [LANES];
    q30_t cos_reg [LANES];
    q30_t sin_next [LANES];
    q30_t cos_next [LANES];
    logic [SIDE_W-1:0] oside_reg;
    logic              ovalid_reg;

    // rotation steps, driven toward z = 0
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            x_next[0][l] = GAIN_Q30;
            y_next[0][l] = '0;
            z_next[0][l] = cw_t'({{(CW-ANGLE_BITS+2){1'b0}}, ang[l][ANGLE_BITS-3:0]});
            q_next[0][l] = ang[l][ANGLE_BITS-1 -: 2];
        end
        for (int k = 0; k < STAGES; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (!z_reg[k][l][CW-1]) begin
                    x_next[k+1][l] = x_reg[k][l] - (y_reg[k][l] >>> k);
                    y_next[k+1][l] = y_reg[k][l] + (x_reg[k][l] >>> k);
                    z_next[k+1][l] = z_reg[k][l] - step_angle(k);
                end else begin
                    x_next[k+1][l] = x_reg[k][l] + (y_reg[k][l] >>> k);
                    y_next[k+1][l] = y_reg[k][l] - (x_reg[k][l] >>> k);
                    z_next[k+1][l] = z_reg[k][l] + step_angle(k);
                end
                q_next[k+1][l] = q_reg[k][l];
            end
        end
    end

    // clamp and map to quadrant
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            case (q_reg[STAGES][l])
                2'd0: begin
                    cos_next[l] = sat_q30(x_reg[STAGES][l]);
                    sin_next[l] = sat_q30(y_reg[STAGES][l]);
                end
                2'd1: begin
                    cos_next[l] = -sat_q30(y_reg[STAGES][l]);
                    sin_next[l] = sat_q30(x_reg[STAGES][l]);
                end
                2'd2: begin
                    cos_next[l] = -sat_q30(x_reg[STAGES][l]);
                    sin_next[l] = -sat_q30(y_reg[STAGES][l]);
                end
                default: begin
                    cos_next[l] = sat_q30(y_reg[STAGES][l]);
                    sin_next[l] = -sat_q30(x_reg[STAGES][l]);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg      <= '0;
            ovalid_reg <= 1'b0;
        end else if (ce) begin
            v_reg      <= {v_reg[STAGES-1:0], in_valid};
            ovalid_reg <= v_reg[STAGES];
        end
        if (ce) begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            q_reg       <= q_next;
            side_reg[0] <= in_side;
            for (int k = 0; k < STAGES; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
            sin_reg   <= sin_next;
            cos_reg   <= cos_next;
            oside_reg <= side_reg[STAGES];
        end
    end

    assign out_valid = ovalid_reg;
    assign sin_q     = sin_reg;
    assign cos_q     = cos_reg;
    assign out_side  = oside_reg;

endmodule
`default_nettype wire

// ----- design/sspa_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspa_sqrt: pipelined integer square root
// Digit-by-digit restoring root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module sspa_sqrt
    import sspa_pkg::*;
#(
    parameter int VAL_W  = 61,
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ce,
    input  logic                      in_valid,
    input  logic [VAL_W-1:0]          in_val,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [(VAL_W+1)/2-1:0]    root,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int ITER = (VAL_W + 1) / 2;
    localparam int RW   = 2 * ITER;

    logic [VAL_W-1:0]  v_reg  [ITER+1];
    logic [VAL_W-1:0]  v_next [ITER+1];
    logic [RW-1:0]     r_reg  [ITER+1];
    logic [RW-1:0]     r_next [ITER+1];
    logic [SIDE_W-1:0] side_reg [ITER+1];
    logic [ITER:0]     val_reg;

    // one trial subtract per stage
    always_comb begin
        logic [RW:0] pow_v;
        logic [RW:0] sum_v;
        logic [RW:0] cur_v;
        v_next[0] = in_val;
        r_next[0] = '0;
        for (int k = 0; k < ITER; k++) begin
            pow_v = '0;
            pow_v[2*(ITER-1-k)] = 1'b1;
            sum_v = {1'b0, r_reg[k]} + pow_v;
            cur_v = (RW+1)'(v_reg[k]);
            if (cur_v >= sum_v) begin
                v_next[k+1] = v_reg[k] - sum_v[VAL_W-1:0];
                r_next[k+1] = (r_reg[k] >> 1) + pow_v[RW-1:0];
            end else begin
                v_next[k+1] = v_reg[k];
                r_next[k+1] = r_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (ce) begin
            val_reg <= {val_reg[ITER-1:0], in_valid};
        end
        if (ce) begin
            v_reg       <= v_next;
            r_reg       <= r_next;
            side_reg[0] <= in_side;
            for (int k = 0; k < ITER; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = val_reg[ITER];
    assign root      = r_reg[ITER][ITER-1:0];
    assign out_side  = side_reg[ITER];

endmodule
`default_nettype wire

// ----- design/sspa_vec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspa_vec: pipelined vectoring CORDIC for the arccosine
// Vectors (u, w) or (w, -u) onto the x axis and clamps to [0, half turn].
// ----------------------------------------------------------------------------
module sspa_vec
    import sspa_pkg::*;
#(
    parameter int STAGES = 30,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  q30_t              u,
    input  root_t             w,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output angle_t            ang,
    output logic [SIDE_W-1:0] out_side
);

    cw_t  x_reg  [STAGES+1];
    cw_t  y_reg  [STAGES+1];
    cw_t  z_reg  [STAGES+1];
    cw_t  x_next [STAGES+1];
    cw_t  y_next [STAGES+1];
    cw_t  z_next [STAGES+1];
    logic [SIDE_W-1:0] side_reg [STAGES+1];
    logic [STAGES:0]   v_reg;

    angle_t            ang_reg;
    angle_t            ang_next;
    logic [SIDE_W-1:0] oside_reg;
    logic              ovalid_reg;

    // start vector, then drive y to zero
    always_comb begin
        if (u[31]) begin
            x_next[0] = cw_t'({{(CW-ROOT_W){1'b0}}, w});
            y_next[0] = -cw_t'(u);
            z_next[0] = QUARTER_TURN;
        end else begin
            x_next[0] = cw_t'(u);
            y_next[0] = cw_t'({{(CW-ROOT_W){1'b0}}, w});
            z_next[0] = '0;
        end
        for (int k = 0; k < STAGES; k++) begin
            if (y_reg[k] > 0) begin
                x_next[k+1] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] + step_angle(k);
            end else begin
                x_next[k+1] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] - step_angle(k);
            end
        end
    end

    // clamp to [0, half turn]
    always_comb begin
        if (z_reg[STAGES][CW-1]) begin
            ang_next = '0;
        end else if (z_reg[STAGES] > HALF_TURN) begin
            ang_next = HALF_TURN[ANGLE_BITS-1:0];
        end else begin
            ang_next = z_reg[STAGES][ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg      <= '0;
            ovalid_reg <= 1'b0;
        end else if (ce) begin
            v_reg      <= {v_reg[STAGES-1:0], in_valid};
            ovalid_reg <= v_reg[STAGES];
        end
        if (ce) begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            side_reg[0] <= in_side;
            for (int k = 0; k < STAGES; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
            ang_reg   <= ang_next;
            oside_reg <= side_reg[STAGES];
        end
    end

    assign out_valid = ovalid_reg;
    assign ang       = ang_reg;
    assign out_side  = oside_reg;

endmodule
`default_nettype wire

// ----- design/sspa_acos.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspa_acos: pipelined arccosine of a Q1.30 value
// Squares u, takes w = sqrt(1 - u*u), then vectors (u, w) to an angle.
// ----------------------------------------------------------------------------
module sspa_acos
    import sspa_pkg::*;
#(
    parameter int STAGES = 30,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  q30_t              u,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output angle_t            ang,
    output root_t             w,
    output logic [SIDE_W-1:0] out_side
);

    localparam int SQ_SIDE_W  = 32 + SIDE_W;
    localparam int VEC_SIDE_W = ROOT_W + SIDE_W;

    logic [2:0]        a_v_reg;
    q30_t              u0_reg, u1_reg, u2_reg;
    logic [SIDE_W-1:0] side0_reg, side1_reg, side2_reg;
    logic [RAD_W-1:0]  sq_reg, rad_reg;
    logic signed [63:0] sq_full;

    logic                 sq_valid;
    root_t                root;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic [VEC_SIDE_W-1:0] vec_side;

    assign sq_full = u0_reg * u0_reg;

    // clamp, square, radicand
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= '0;
        end else if (ce) begin
            a_v_reg <= {a_v_reg[1:0], in_valid};
        end
        if (ce) begin
            u0_reg    <= sat_q30(cw_t'(u));
            side0_reg <= in_side;
            sq_reg    <= sq_full[RAD_W-1:0];
            u1_reg    <= u0_reg;
            side1_reg <= side0_reg;
            rad_reg   <= RAD_ONE - sq_reg;
            u2_reg    <= u1_reg;
            side2_reg <= side1_reg;
        end
    end

    sspa_sqrt #(
        .VAL_W  (RAD_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (a_v_reg[2]),
        .in_val    (rad_reg),
        .in_side   ({side2_reg, u2_reg}),
        .out_valid (sq_valid),
        .root      (root),
        .out_side  (sq_side)
    );

    sspa_vec #(
        .STAGES (STAGES),
        .SIDE_W (VEC_SIDE_W)
    ) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .u         (sq_side[31:0]),
        .w         (root),
        .in_side   ({sq_side[SQ_SIDE_W-1:32], root}),
        .out_valid (out_valid),
        .ang       (ang),
        .out_side  (vec_side)
    );

    assign w        = vec_side[ROOT_W-1:0];
    assign out_side = vec_side[VEC_SIDE_W-1:ROOT_W];

endmodule
`default_nettype wire

// ----- design/sspa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspa_div: pipelined restoring divider for the position-angle cosine
// Quotient n / d truncated to Q1.30, clamped to +-1, one bit per stage.
// ----------------------------------------------------------------------------
module sspa_div
    import sspa_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic signed [63:0] num,
    input  logic [RAD_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output q30_t              ratio,
    output logic [SIDE_W-1:0] out_side
);

    localparam int REM_W = RAD_W + 2;

    logic [REM_W-1:0]     rem_reg  [FRAC_BITS+1];
    logic [REM_W-1:0]     rem_next [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] q_reg    [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] q_next   [FRAC_BITS+1];
    logic [RAD_W-1:0]     d_reg    [FRAC_BITS+1];
    logic                 neg_reg  [FRAC_BITS+1];
    logic                 sat_reg  [FRAC_BITS+1];
    logic                 sat_next [FRAC_BITS+1];
    logic [SIDE_W-1:0]    side_reg [FRAC_BITS+1];
    logic [FRAC_BITS:0]   v_reg;

    logic signed [63:0] mag_full;
    q30_t               ratio_reg, ratio_next;
    logic [SIDE_W-1:0]  oside_reg;
    logic               ovalid_reg;

    assign mag_full = num[63] ? -num : num;

    // shift, compare, subtract
    always_comb begin
        logic [REM_W-1:0] rem2;
        rem_next[0] = mag_full[REM_W-1:0];
        q_next[0]   = '0;
        sat_next[0] = (den == '0);
        for (int k = 0; k < FRAC_BITS; k++) begin
            rem2 = rem_reg[k] << 1;
            sat_next[k+1] = sat_reg[k] ||
                            ((k == 0) && (rem_reg[k] >= REM_W'(d_reg[k])));
            if (rem2 >= REM_W'(d_reg[k])) begin
                rem_next[k+1] = rem2 - REM_W'(d_reg[k]);
                q_next[k+1]   = {q_reg[k][FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_next[k+1] = rem2;
                q_next[k+1]   = {q_reg[k][FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // sign and clamp
    always_comb begin
        if (sat_reg[FRAC_BITS]) begin
            ratio_next = neg_reg[FRAC_BITS] ? -ONE_Q30 : ONE_Q30;
        end else if (neg_reg[FRAC_BITS]) begin
            ratio_next = -q30_t'({2'b00, q_reg[FRAC_BITS]});
        end else begin
            ratio_next = q30_t'({2'b00, q_reg[FRAC_BITS]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg      <= '0;
            ovalid_reg <= 1'b0;
        end else if (ce) begin
            v_reg      <= {v_reg[FRAC_BITS-1:0], in_valid};
            ovalid_reg <= v_reg[FRAC_BITS];
        end
        if (ce) begin
            rem_reg     <= rem_next;
            q_reg       <= q_next;
            sat_reg     <= sat_next;
            d_reg[0]    <= den;
            neg_reg[0]  <= num[63];
            side_reg[0] <= in_side;
            for (int k = 0; k < FRAC_BITS; k++) begin
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            ratio_reg <= ratio_next;
            oside_reg <= side_reg[FRAC_BITS];
        end
    end

    assign out_valid = ovalid_reg;
    assign ratio     = ratio_reg;
    assign out_side  = oside_reg;

endmodule
`default_nettype wire

// ----- design/sphere_separation_position_angle_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_separation_position_angle_top: sky separation and position angle
// Great-circle separation and position angle of two sky positions.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                           | tuser
//  s_      | in  | ra_first, ra_second, dec_first, dec_second   | -
//  m_      | out | separation, position_angle                   | degenerate
//
//  Latency is set by three CORDIC pipelines, two 31-stage square roots and
//  the 30-stage divider.
//  One beat is accepted every cycle while the output register drains.
//  A stall on m_tready freezes the whole pipeline; nothing is lost or repeated.
//  aresetn clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module sphere_separation_position_angle_top
    import sspa_pkg::*;
#(
    parameter int CORDIC_STAGES = 30
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // ra_first, ra_second, dec_first, dec_second
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // separation, position_angle
    output logic              m_tuser    // degenerate
);

    localparam logic signed [63:0] ONE_W      = 64'sd1073741824;
    localparam logic signed [63:0] HALF_LSB_W = 64'sd536870912;
    localparam int SIDE1_W = 4*32 + 2;
    localparam int SIDE2_W = ANGLE_BITS + 2;

    logic ce;

    // input fields
    angle_t ra1, ra2;
    q30_t   dec1, dec2, dec1_c, dec2_c;
    angle_t ra_back;

    assign ra1  = s_tdata[31:0];
    assign ra2  = s_tdata[63:32];
    assign dec1 = s_tdata[95:64];
    assign dec2 = s_tdata[127:96];

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // clamp declinations at the poles
    always_comb begin
        dec1_c = dec1;
        dec2_c = dec2;
        if (dec1 > ONE_Q30) begin
            dec1_c = ONE_Q30;
        end else if (dec1 < -ONE_Q30) begin
            dec1_c = -ONE_Q30;
        end
        if (dec2 > ONE_Q30) begin
            dec2_c = ONE_Q30;
        end else if (dec2 < -ONE_Q30) begin
            dec2_c = -ONE_Q30;
        end
        ra_back = ra2 - ra1;
    end

    logic   a_v_reg;
    angle_t a_ang_reg [3];
    logic   a_neg_reg, a_pole_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (ce) begin
            a_v_reg <= s_tvalid;
        end
        if (ce) begin
            a_ang_reg[0] <= dec1_c;
            a_ang_reg[1] <= dec2_c;
            a_ang_reg[2] <= ra1 - ra2;
            a_neg_reg    <= ra_back > HALF_TURN[ANGLE_BITS-1:0];
            a_pole_reg   <= (dec1_c == ONE_Q30) || (dec1_c == -ONE_Q30);
        end
    end

    // sines and cosines of both declinations and the RA difference
    logic       rot_valid;
    q30_t       rot_sin [3];
    q30_t       rot_cos [3];
    logic [1:0] rot_side;

    sspa_rot #(
        .STAGES (CORDIC_STAGES),
        .LANES  (3),
        .SIDE_W (2)
    ) u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (a_v_reg),
        .ang       (a_ang_reg),
        .in_side   ({a_neg_reg, a_pole_reg}),
        .out_valid (rot_valid),
        .sin_q     (rot_sin),
        .cos_q     (rot_cos),
        .out_side  (rot_side)
    );

    // law of cosines: products, then rounded sum
    q30_t c1p, c2p;
    logic signed [63:0] cc_full, cc_rnd, ss_full;

    assign c1p     = rot_cos[0][31] ? '0 : rot_cos[0];
    assign c2p     = rot_cos[1][31] ? '0 : rot_cos[1];
    assign cc_full = c1p * c2p;
    assign cc_rnd  = (cc_full + HALF_LSB_W) >>> FRAC_BITS;
    assign ss_full = rot_sin[0] * rot_sin[1];

    logic [2:0]         m_v_reg;
    logic signed [63:0] m1_ss_reg, m2_ss_reg, m2_t_reg;
    q30_t               m1_cc_reg, m1_cda_reg;
    q30_t               m1_s1_reg, m1_s2_reg, m1_c1_reg;
    q30_t               m2_s1_reg, m2_s2_reg, m2_c1_reg;
    q30_t               m3_s1_reg, m3_s2_reg, m3_c1_reg, m3_u_reg;
    logic [1:0]         m1_fl_reg, m2_fl_reg, m3_fl_reg;
    logic signed [63:0] u_sum, u_rnd;
    q30_t               u_next;

    always_comb begin
        u_sum = m2_ss_reg + m2_t_reg;
        u_rnd = (u_sum + HALF_LSB_W) >>> FRAC_BITS;
        if (u_rnd > ONE_W) begin
            u_next = ONE_Q30;
        end else if (u_rnd < -ONE_W) begin
            u_next = -ONE_Q30;
        end else begin
            u_next = u_rnd[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= '0;
        end else if (ce) begin
            m_v_reg <= {m_v_reg[1:0], rot_valid};
        end
        if (ce) begin
            m1_ss_reg  <= ss_full;
            m1_cc_reg  <= cc_rnd[31:0];
            m1_cda_reg <= rot_cos[2];
            m1_s1_reg  <= rot_sin[0];
            m1_s2_reg  <= rot_sin[1];
            m1_c1_reg  <= c1p;
            m1_fl_reg  <= rot_side;
            m2_t_reg   <= m1_cc_reg * m1_cda_reg;
            m2_ss_reg  <= m1_ss_reg;
            m2_s1_reg  <= m1_s1_reg;
            m2_s2_reg  <= m1_s2_reg;
            m2_c1_reg  <= m1_c1_reg;
            m2_fl_reg  <= m1_fl_reg;
            m3_u_reg   <= u_next;
            m3_s1_reg  <= m2_s1_reg;
            m3_s2_reg  <= m2_s2_reg;
            m3_c1_reg  <= m2_c1_reg;
            m3_fl_reg  <= m2_fl_reg;
        end
    end

    // separation = acos(u)
    logic               sep_valid;
    angle_t             sep_ang;
    root_t              sep_w;
    logic [SIDE1_W-1:0] sep_side;

    sspa_acos #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE1_W)
    ) u_acos_sep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (m_v_reg[2]),
        .u         (m3_u_reg),
        .in_side   ({m3_u_reg, m3_c1_reg, m3_s2_reg, m3_s1_reg, m3_fl_reg}),
        .out_valid (sep_valid),
        .ang       (sep_ang),
        .w         (sep_w),
        .out_side  (sep_side)
    );

    // numerator and denominator of the position-angle cosine
    q30_t sp_s1, sp_s2, sp_c1, sp_u;
    logic sp_neg, sp_pole;
    logic signed [63:0] p_full, d_full, s2_wide;

    assign sp_pole = sep_side[0];
    assign sp_neg  = sep_side[1];
    assign sp_s1   = sep_side[33:2];
    assign sp_s2   = sep_side[65:34];
    assign sp_c1   = sep_side[97:66];
    assign sp_u    = sep_side[129:98];
    assign p_full  = sp_s1 * sp_u;
    assign d_full  = sp_c1 * $signed({1'b0, sep_w});

    logic [1:0]         d_v_reg;
    logic signed [63:0] d0_p_reg, d1_n_reg;
    logic [RAD_W-1:0]   d0_d_reg, d1_d_reg;
    q30_t               d0_s2_reg;
    logic [SIDE2_W-1:0] d0_side_reg, d1_side_reg;

    assign s2_wide = {{32{d0_s2_reg[31]}}, d0_s2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= '0;
        end else if (ce) begin
            d_v_reg <= {d_v_reg[0], sep_valid};
        end
        if (ce) begin
            d0_p_reg    <= p_full;
            d0_d_reg    <= d_full[RAD_W-1:0];
            d0_s2_reg   <= sp_s2;
            d0_side_reg <= {sep_ang, sp_neg, sp_pole || (sep_ang == '0)};
            d1_n_reg    <= (s2_wide <<< FRAC_BITS) - d0_p_reg;
            d1_d_reg    <= d0_d_reg;
            d1_side_reg <= d0_side_reg;
        end
    end

    logic               div_valid;
    q30_t               div_ratio;
    logic [SIDE2_W-1:0] div_side;

    sspa_div #(
        .SIDE_W (SIDE2_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (d_v_reg[1]),
        .num       (d1_n_reg),
        .den       (d1_d_reg),
        .in_side   (d1_side_reg),
        .out_valid (div_valid),
        .ratio     (div_ratio),
        .out_side  (div_side)
    );

    // position angle = acos(ratio)
    logic               pa_valid;
    angle_t             pa_ang;
    logic [SIDE2_W-1:0] pa_side;

    sspa_acos #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE2_W)
    ) u_acos_pa (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (div_valid),
        .u         (div_ratio),
        .in_side   (div_side),
        .out_valid (pa_valid),
        .ang       (pa_ang),
        .w         (),
        .out_side  (pa_side)
    );

    // sign by RA order, force zero when degenerate
    logic   out_valid_reg, out_degen_reg;
    angle_t out_sep_reg, out_pa_reg, pa_next;

    always_comb begin
        if (pa_side[0]) begin
            pa_next = '0;
        end else if (pa_side[1]) begin
            pa_next = angle_t'(0) - pa_ang;
        end else begin
            pa_next = pa_ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= pa_valid;
        end
        if (ce) begin
            out_sep_reg   <= pa_side[SIDE2_W-1:2];
            out_pa_reg    <= pa_next;
            out_degen_reg <= pa_side[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pa_reg, out_sep_reg};
    assign m_tuser  = out_degen_reg;

endmodule
`default_nettype wire

// ----- design/sspa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspa_checker: port-level checks for the separation pipeline
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module sspa_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [127:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic         m_tuser
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed under stall");

    // degenerate results carry a zero position angle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[63:32] == 32'd0)
    else $error("degenerate beat with nonzero position angle");

    // separation never exceeds a half turn
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:0] <= 32'h8000_0000)
    else $error("separation above half turn");

    // input side open whenever the output register is empty
    assert property (@(posedge aclk)
        !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
    else $error("result beat right after reset");

endmodule

bind sphere_separation_position_angle_top sspa_checker u_sspa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- verif/tb_sphere_separation_position_angle_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_separation_position_angle_top: self-checking bench for the sky
// separation pipeline
// A directed table of corner positions is sent first, then random pairs
// under several idle and stall patterns, with one long output hold-off.
// Every output beat is checked against a local fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_sphere_separation_position_angle_top;
    import sspa_pkg::*;

    localparam int  STAGES      = 30;
    localparam int  PIPE_DEPTH  = 3 * STAGES + 115;
    localparam int  RAND_ITEMS  = 1800;
    localparam longint Q_ONE    = 64'sd1 << 30;
    localparam longint Q_HALF   = 64'sd1 << 29;
    localparam longint K_GAIN   = 64'sd652032874;
    localparam longint QTURN    = 64'sd1 << 30;
    localparam longint HTURN    = 64'sd1 << 31;

    typedef struct packed {
        logic [31:0] sep;
        logic [31:0] pa;
        logic        degen;
    } sky_result_t;

    typedef struct {
        logic [31:0] ra1;
        logic [31:0] ra2;
        logic [31:0] dec1;
        logic [31:0] dec2;
        bit          pinned;   // first point at or past a pole: pa 0, degenerate
    } sky_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    sky_result_t  pending_results[$];
    int           fail_cnt;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_req;
    int           hold_cnt;

    longint atan_tab[STAGES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    sphere_separation_position_angle_top #(.CORDIC_STAGES(STAGES)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_one(input longint v);
        if (v > Q_ONE) return Q_ONE;
        if (v < -Q_ONE) return -Q_ONE;
        return v;
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + Q_HALF) >>> 30;
    endfunction

    // rotation CORDIC, quadrant from the top two bits
    function automatic void rot_sincos(input logic [31:0] ang,
                                       output longint sn, output longint cs);
        longint x, y, z, t;
        x = K_GAIN;
        y = 0;
        z = longint'(ang[29:0]);
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_tab[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_tab[i];
            end
        end
        x = clamp_one(x);
        y = clamp_one(y);
        case (ang[31:30])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // vectoring CORDIC arccosine, also hands back sqrt(1 - u^2)
    function automatic longint vec_arccos(input longint u_in, output longint w);
        longint u, x, y, z, t;
        u = clamp_one(u_in);
        w = floor_sqrt(longint'(Q_ONE * Q_ONE - u * u));
        if (u < 0) begin
            x = w; y = -u; z = QTURN;
        end else begin
            x = u; y = w; z = 0;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y > 0) begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_tab[i];
            end else begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > HTURN) z = HTURN;
        return z;
    endfunction

    // truncating Q1.30 quotient, saturated to +-1
    function automatic longint div_q30(input longint n, input longint d);
        longint unsigned mag, rem, q;
        if (d <= 0) return (n >= 0) ? Q_ONE : -Q_ONE;
        mag = (n < 0) ? longint'(-n) : n;
        if (mag >= d) return (n < 0) ? -Q_ONE : Q_ONE;
        rem = mag;
        q = 0;
        for (int k = 0; k < 30; k++) begin
            rem <<= 1;
            q <<= 1;
            if (rem >= d) begin
                rem -= d;
                q |= 1;
            end
        end
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_dec(input logic [31:0] raw);
        longint d;
        d = longint'(signed'(raw));
        if (d > QTURN) d = QTURN;
        if (d < -QTURN) d = -QTURN;
        return d;
    endfunction

    function automatic sky_result_t predict_sky(input logic [127:0] beat);
        logic [31:0] ra1, ra2, dra;
        longint d1, d2, s1, c1, s2, c2, sda, cda, u, w, sep, pa, wdum;
        sky_result_t r;
        ra1 = beat[31:0];
        ra2 = beat[63:32];
        d1  = clamp_dec(beat[95:64]);
        d2  = clamp_dec(beat[127:96]);
        rot_sincos(d1[31:0], s1, c1);
        rot_sincos(d2[31:0], s2, c2);
        if (c1 < 0) c1 = 0;
        if (c2 < 0) c2 = 0;
        dra = ra1 - ra2;
        rot_sincos(dra, sda, cda);
        u = clamp_one(round_q30(s1 * s2 + round_q30(c1 * c2) * cda));
        sep = vec_arccos(u, w);
        pa = 0;
        r.degen = (d1 == QTURN) || (d1 == -QTURN) || (sep == 0);
        if (!r.degen) begin
            pa = vec_arccos(div_q30(s2 * Q_ONE - s1 * u, c1 * w), wdum);
            if ((ra2 - ra1) > 32'h8000_0000) pa = -pa;
        end
        r.sep = sep[31:0];
        r.pa  = pa[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_pair(input logic [127:0] beat, input bit pinned);
        sky_result_t e;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        e = predict_sky(beat);
        if (pinned) begin
            e.pa    = '0;
            e.degen = 1'b1;
        end
        pending_results.push_back(e);
        // each cycle idles with the phase's probability
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] rand_dec();
        if ($urandom_range(49) == 0) return $urandom();   // may lie past a pole
        return $urandom_range(32'h8000_0000) - 32'h4000_0000;
    endfunction

    function automatic logic [127:0] rand_pair();
        logic [31:0] ra1, ra2, d1, d2;
        ra1 = $urandom();
        ra2 = $urandom();
        d1  = rand_dec();
        d2  = rand_dec();
        case ($urandom_range(9))
            0: begin ra2 = ra1; d2 = d1; end                        // coincident
            1: begin ra2 = ra1 + 32'h8000_0000; d2 = -d1; end       // antipodal
            2: d1 = ($urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000)
                    + $urandom_range(64) - 32;                      // near a pole
            3: ra2 = ra1 + $urandom_range(512) - 256;               // close in ra
            default: ;
        endcase
        return {d2, d1, ra2, ra1};
    endfunction

    sky_row_t corner_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 32'h8000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{32'h1234_5678, 32'h1234_5678, 32'h0ABC_DEF0, 32'h0ABC_DEF0, 1'b0},
        '{32'h1000_0000, 32'h9000_0000, 32'h2000_0000, 32'hE000_0000, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h4000_0000, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hC000_0000, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0},
        '{32'h2000_0000, 32'h6000_0000, 32'h3FFF_FFFF, 32'h1000_0000, 1'b0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hC000_0001, 32'h3000_0000, 1'b0},
        '{32'h0000_0000, 32'h3000_0000, 32'h4000_0000, 32'h1000_0000, 1'b1},
        '{32'h7000_0000, 32'h0000_0000, 32'hC000_0000, 32'h2000_0000, 1'b1},
        '{32'h0000_0000, 32'h0100_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1},
        '{32'hFFFF_FFFF, 32'h0100_0000, 32'h8000_0000, 32'hF000_0000, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, 32'h4000_0000, 32'h4000_0000, 1'b1}
    };

    // stimulus and end of run
    initial begin
        int guard;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        fail_cnt       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_rows[i])
            send_pair({corner_rows[i].dec2, corner_rows[i].dec1,
                       corner_rows[i].ra2, corner_rows[i].ra1}, corner_rows[i].pinned);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            // long output hold-off while input keeps coming
            if (ph == 0) hold_req = 1'b1;
            for (int n = 0; n < RAND_ITEMS / 4; n++) send_pair(rand_pair(), 1'b0);
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (PIPE_DEPTH + 20) @(posedge aclk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 4 * PIPE_DEPTH;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each output beat with the oldest prediction
    always @(posedge aclk) begin
        sky_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat sep=%h pa=%h degen=%b", $time,
                         m_tdata[31:0], m_tdata[63:32], m_tuser);
                fail_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.sep) begin
                    $display("%0t: separation expected %h actual %h", $time,
                             e.sep, m_tdata[31:0]);
                    fail_cnt++;
                end
                if (m_tdata[63:32] !== e.pa) begin
                    $display("%0t: position_angle expected %h actual %h", $time,
                             e.pa, m_tdata[63:32]);
                    fail_cnt++;
                end
                if (m_tuser !== e.degen) begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             e.degen, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    // run limit
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
